>>> rtl/ats_pkg.sv
// Package for the alias table sampler: kind codes, controller states and defaults.
// Used by alias_table_sampler; depends on nothing else.
package ats_pkg;

   localparam int MAX_ENTRIES_DEF   = 1024;
   localparam int FRACTION_BITS_DEF = 32;
   localparam int WEIGHT_W          = 33;
   localparam int RANDOM_W          = 32;
   localparam int PORT_IDX_W        = 10;
   localparam int SIZE_W            = 11;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_BUILD  = 2'd1,
      KIND_SAMPLE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic {
      RESULT_BUILD  = 1'b0,
      RESULT_SAMPLE = 1'b1
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_MUL,
      ST_SCAN_WR,
      ST_CHECK,
      ST_PAIR_POP,
      ST_PAIR_RD,
      ST_PAIR_WR,
      ST_DRAIN_RD,
      ST_DRAIN_WR,
      ST_FINISH,
      ST_SAMP_COL,
      ST_SAMP_CMP
   } state_type;

endpackage

>>> rtl/alias_table_sampler.sv
// Walker alias table sampler: weight, probability, alias and stack memories with
// a sequencer that builds the tables and answers sample requests. Uses ats_pkg.
//
// Usage. Words enter on the req_ channel: req_tuser holds the kind (load, build,
// sample), req_tdata the entry index, weight and two uniform randoms. A load
// word writes one normalized weight and gives no result. A build word turns the
// loaded weights into the alias tables and returns one word with result kind
// "build finished". A sample word returns one word carrying the chosen index.
// The csr_ channel writes the table size; write it only while the block is idle.
//
// Sequence. A load writes its weight as it is accepted and leaves the sequencer
// idle. A sample has its randoms registered at acceptance; ST_SAMP_COL then forms
// the column with one multiply and issues the table reads, and ST_SAMP_CMP does
// the compare and loads the result register. A build scans the n entries in turn
// (weight read, scale multiply, write and stack push), then runs pairing steps
// and one step per leftover stack entry, each step including its pass through
// the check state. One word is worked on at a time; req_tready is high only
// while the sequencer is idle.
//
// Reset clears the sequencer, the stack counts and the built size, so a sample
// before any build returns index zero. The memories are not cleared. If the
// receiver stalls, the result waits in the output register and further loads
// are still taken; a build or sample finishing meanwhile waits in its last step.
module alias_table_sampler
   import ats_pkg::*;
#(
   parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [9:0] entry_index, [42:10] weight, [74:43] random_x, [106:75] random_y
   input  logic [111:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [9:0] sample_index
   output logic [15:0]  rsp_tdata,
   // [0] result_kind
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [10:0]  csr_data
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int FX_W   = FRACTION_BITS + 1;
   localparam int PROB_W = FRACTION_BITS + 1 + IDX_W;
   localparam int UP     = (FRACTION_BITS >= 32) ? FRACTION_BITS - 32 : 0;
   localparam int DOWN   = (FRACTION_BITS >= 32) ? 0 : 32 - FRACTION_BITS;
   localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1) << FRACTION_BITS;

   // Memories.
   logic [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
   logic [PROB_W-1:0]   prob_mem   [MAX_ENTRIES];
   logic [IDX_W-1:0]    alias_mem  [MAX_ENTRIES];
   logic [IDX_W-1:0]    over_mem   [MAX_ENTRIES];
   logic [IDX_W-1:0]    under_mem  [MAX_ENTRIES];

   logic [WEIGHT_W-1:0] weight_rd_ff;
   logic [PROB_W-1:0]   prob_a_rd_ff, prob_b_rd_ff;
   logic [IDX_W-1:0]    alias_rd_ff, over_rd_ff, under_rd_ff;

   logic                weight_we;
   logic [IDX_W-1:0]    weight_wa, weight_ra;
   logic                prob_we, alias_we, over_we, under_we;
   logic [IDX_W-1:0]    prob_wa, alias_wa, over_wa, under_wa;
   logic [PROB_W-1:0]   prob_wd;
   logic [IDX_W-1:0]    alias_wd, over_wd, under_wd;
   logic [IDX_W-1:0]    prob_ra_a, prob_ra_b, alias_ra, over_ra, under_ra;

   // Control and data registers.
   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff;
   logic [CNT_W-1:0]    n_ff, n_in, built_ff, built_in, k_ff, k_in;
   logic [CNT_W-1:0]    oc_ff, oc_in, uc_ff, uc_in;
   logic [PROB_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]    big_ff, big_in, small_ff, small_in, col_ff, col_in;
   logic                drain_over_ff, drain_over_in;
   logic [RANDOM_W-1:0] x_ff, x_in, y_ff, y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;

   // Request fields.
   kind_type            req_kind;
   logic [PORT_IDX_W-1:0] req_index;
   logic [WEIGHT_W-1:0] req_weight;
   logic [RANDOM_W-1:0] req_x, req_y;
   logic                req_fire, rsp_free;

   // Helpers.
   logic [31:0]         size_wide, used_wide;
   logic [16:0]         index_wide;
   logic [FRACTION_BITS+32:0] w_ext, y_ext;
   logic [FX_W-1:0]     w_fx, y_fx;
   logic [CNT_W+FX_W-1:0] scale_prod;
   logic [CNT_W+RANDOM_W-1:0] col_prod;
   logic [CNT_W-1:0]    col_raw, col_sel;
   logic [PROB_W:0]     pair_sum;
   logic [PROB_W-1:0]   pair_p;
   logic [CNT_W-1:0]    oc_dec, uc_dec;
   logic [IDX_W-1:0]    drain_e;
   logic [16:0]         out_wide;

   assign req_kind   = kind_type'(req_tuser);
   assign req_index  = req_tdata[9:0];
   assign req_weight = req_tdata[42:10];
   assign req_x      = req_tdata[74:43];
   assign req_y      = req_tdata[106:75];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign out_wide   = 17'(rsp_idx_ff);
   assign rsp_tdata  = {6'd0, out_wide[PORT_IDX_W-1:0]};

   // Size in use: zero counts as one, anything above the capacity is clipped.
   assign size_wide  = 32'(size_ff);
   always_comb begin
      used_wide = size_wide;
      if (size_wide == 32'd0) used_wide = 32'd1;
      if (size_wide > 32'(MAX_ENTRIES)) used_wide = 32'(MAX_ENTRIES);
   end

   assign index_wide = 17'(req_index);

   // Q1.32 weights and Q0.32 randoms to the probability format.
   assign w_ext      = ((FRACTION_BITS+33)'(weight_rd_ff) << UP) >> DOWN;
   assign w_fx       = w_ext[FX_W-1:0];
   assign y_ext      = ((FRACTION_BITS+33)'(y_ff) << UP) >> DOWN;
   assign y_fx       = y_ext[FX_W-1:0];

   assign scale_prod = n_ff * w_fx;
   assign col_prod   = built_ff * x_ff;
   assign col_raw    = col_prod[CNT_W+RANDOM_W-1:RANDOM_W];
   // The column is clipped to the last built entry; with no table it is zero.
   assign col_sel    = (built_ff == '0) ? '0
                     : (col_raw >= built_ff) ? (built_ff - CNT_W'(1)) : col_raw;
   assign pair_sum   = {1'b0, prob_a_rd_ff} + {1'b0, prob_b_rd_ff} - {1'b0, ONE_FX};
   assign pair_p     = pair_sum[PROB_W-1:0];
   assign oc_dec     = oc_ff - CNT_W'(1);
   assign uc_dec     = uc_ff - CNT_W'(1);
   assign drain_e    = drain_over_ff ? over_rd_ff : under_rd_ff;

   // Memory ports.
   always_ff @(posedge clock) begin
      if (weight_we) weight_mem[weight_wa] <= req_weight;
      weight_rd_ff <= weight_mem[weight_ra];
   end

   always_ff @(posedge clock) begin
      if (prob_we) prob_mem[prob_wa] <= prob_wd;
      prob_a_rd_ff <= prob_mem[prob_ra_a];
      prob_b_rd_ff <= prob_mem[prob_ra_b];
   end

   always_ff @(posedge clock) begin
      if (alias_we) alias_mem[alias_wa] <= alias_wd;
      alias_rd_ff <= alias_mem[alias_ra];
   end

   always_ff @(posedge clock) begin
      if (over_we) over_mem[over_wa] <= over_wd;
      over_rd_ff <= over_mem[over_ra];
   end

   always_ff @(posedge clock) begin
      if (under_we) under_mem[under_wa] <= under_wd;
      under_rd_ff <= under_mem[under_ra];
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         built_ff     <= '0;
         oc_ff        <= '0;
         uc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) size_ff <= csr_data;
         built_ff     <= built_in;
         oc_ff        <= oc_in;
         uc_ff        <= uc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      big_ff        <= big_in;
      small_ff      <= small_in;
      col_ff        <= col_in;
      drain_over_ff <= drain_over_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      built_in      = built_ff;
      k_in          = k_ff;
      oc_in         = oc_ff;
      uc_in         = uc_ff;
      p_in          = p_ff;
      big_in        = big_ff;
      small_in      = small_ff;
      col_in        = col_ff;
      drain_over_in = drain_over_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;

      weight_we = 1'b0;
      weight_wa = index_wide[IDX_W-1:0];
      weight_ra = k_ff[IDX_W-1:0];
      prob_we   = 1'b0;
      prob_wa   = k_ff[IDX_W-1:0];
      prob_wd   = p_ff;
      prob_ra_a = col_ff;
      prob_ra_b = small_ff;
      alias_we  = 1'b0;
      alias_wa  = k_ff[IDX_W-1:0];
      alias_wd  = k_ff[IDX_W-1:0];
      alias_ra  = col_ff;
      over_we   = 1'b0;
      over_wa   = oc_ff[IDX_W-1:0];
      over_wd   = k_ff[IDX_W-1:0];
      over_ra   = oc_dec[IDX_W-1:0];
      under_we  = 1'b0;
      under_wa  = uc_ff[IDX_W-1:0];
      under_wd  = k_ff[IDX_W-1:0];
      under_ra  = uc_dec[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in = req_x;
               y_in = req_y;
               unique case (req_kind)
                  KIND_LOAD: begin
                     weight_we = (32'(index_wide) < 32'(MAX_ENTRIES));
                  end
                  KIND_BUILD: begin
                     n_in     = used_wide[CNT_W-1:0];
                     k_in     = '0;
                     oc_in    = '0;
                     uc_in    = '0;
                     state_in = ST_SCAN_RD;
                  end
                  KIND_SAMPLE: begin
                     state_in = ST_SAMP_COL;
                  end
                  KIND_NONE: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            p_in     = scale_prod[PROB_W-1:0];
            state_in = ST_SCAN_WR;
         end
         ST_SCAN_WR: begin
            prob_we  = 1'b1;
            alias_we = 1'b1;
            if (p_ff > ONE_FX) begin
               over_we = 1'b1;
               oc_in   = oc_ff + CNT_W'(1);
            end else if (p_ff < ONE_FX) begin
               under_we = 1'b1;
               uc_in    = uc_ff + CNT_W'(1);
            end
            k_in = k_ff + CNT_W'(1);
            if (k_ff == n_ff - CNT_W'(1)) state_in = ST_CHECK;
            else state_in = ST_SCAN_RD;
         end
         ST_CHECK: begin
            priority if (oc_ff != '0 && uc_ff != '0) state_in = ST_PAIR_POP;
            else if (oc_ff != '0 || uc_ff != '0) state_in = ST_DRAIN_RD;
            else state_in = ST_FINISH;
         end
         ST_PAIR_POP: begin
            // Stack tops are read here and arrive in the next cycle.
            state_in = ST_PAIR_RD;
         end
         ST_PAIR_RD: begin
            big_in    = over_rd_ff;
            small_in  = under_rd_ff;
            prob_ra_a = over_rd_ff;
            prob_ra_b = under_rd_ff;
            state_in  = ST_PAIR_WR;
         end
         ST_PAIR_WR: begin
            alias_we = 1'b1;
            alias_wa = small_ff;
            alias_wd = big_ff;
            prob_we  = 1'b1;
            prob_wa  = big_ff;
            prob_wd  = pair_p;
            oc_in    = oc_dec;
            uc_in    = uc_dec;
            over_wa  = oc_dec[IDX_W-1:0];
            over_wd  = big_ff;
            under_wa = uc_dec[IDX_W-1:0];
            under_wd = big_ff;
            if (pair_p > ONE_FX) begin
               over_we = 1'b1;
               oc_in   = oc_ff;
            end else if (pair_p < ONE_FX) begin
               under_we = 1'b1;
               uc_in    = uc_ff;
            end
            state_in = ST_CHECK;
         end
         ST_DRAIN_RD: begin
            drain_over_in = (oc_ff != '0);
            if (oc_ff != '0) oc_in = oc_dec;
            else uc_in = uc_dec;
            state_in = ST_DRAIN_WR;
         end
         ST_DRAIN_WR: begin
            // Leftover entries become full columns that alias themselves.
            prob_we  = 1'b1;
            prob_wa  = drain_e;
            prob_wd  = ONE_FX;
            alias_we = 1'b1;
            alias_wa = drain_e;
            alias_wd = drain_e;
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               built_in     = n_ff;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RESULT_BUILD;
               rsp_idx_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_SAMP_COL: begin
            col_in    = col_sel[IDX_W-1:0];
            prob_ra_a = col_sel[IDX_W-1:0];
            alias_ra  = col_sel[IDX_W-1:0];
            state_in  = ST_SAMP_CMP;
         end
         ST_SAMP_CMP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RESULT_SAMPLE;
               if (built_ff == '0) rsp_idx_in = '0;
               else if (PROB_W'(y_fx) < prob_a_rd_ff) rsp_idx_in = col_ff;
               else rsp_idx_in = alias_rd_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The two stacks never hold more entries than the table being built.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(oc_ff) + 32'(uc_ff) <= 32'(n_ff)) || state_ff == ST_IDLE
      || state_ff == ST_SAMP_COL || state_ff == ST_SAMP_CMP)
      else $error("stack counts exceed table size");

   // A pairing step only starts with both stacks non-empty.
   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR_POP |-> (oc_ff != '0 && uc_ff != '0))
      else $error("pairing with an empty stack");

   // A result is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff
      && rsp_kind_ff == $past(rsp_kind_ff) && rsp_idx_ff == $past(rsp_idx_ff))
      else $error("pending result overwritten");

   // A build finishes with a non-zero built size.
   a_built: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> built_ff != '0)
      else $error("build finished with zero size");

endmodule
